// File: sv/fgl_pkg.sv
// ----------------------------------------------------------------------------
// fgl_pkg
// Shared types and constants of the face gradient limiter.
// ----------------------------------------------------------------------------
package fgl_pkg;

  localparam int unsigned DefCellCount = 4096;
  localparam int unsigned DefValueBits = 32;
  localparam int unsigned CellW        = 12;
  localparam int unsigned LimitW       = 17;
  localparam int unsigned FactorW      = 24;
  localparam int unsigned FracW        = 16;
  localparam int unsigned MulChunk     = 8;

  typedef logic [CellW-1:0]   cell_t;
  typedef logic [LimitW-1:0]  limit_t;
  typedef logic [FactorW-1:0] factor_t;
  typedef logic [1:0]         action_t;
  typedef logic [0:0]         cfg_index_t;

  localparam action_t ActInterior = 2'd0;
  localparam action_t ActBoundary = 2'd1;
  localparam action_t ActRead     = 2'd2;
  localparam action_t ActUnused   = 2'd3;

  localparam cfg_index_t CfgEnable = 1'b0;
  localparam cfg_index_t CfgFactor = 1'b1;

  localparam limit_t LimitOne = limit_t'(65536);

endpackage

// File: sv/fgl_ram.sv
// ----------------------------------------------------------------------------
// fgl_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module fgl_ram #(
  parameter int unsigned Width = 17,
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/face_gradient_limiter_unit.sv
// ----------------------------------------------------------------------------
// face_gradient_limiter_unit
// Face-limited gradient limiter: per-cell Q1.16 limiter store, lowered by
// face overshoots, read and reset to 1.0 by read transactions.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_stall_o   | action_i, cells, values, extrapolations
//  out     | out       | out_valid_o/out_stall_i | limiter_value_o
//
//  Face transaction: 3 multiply steps for the widening, then 16 steps of the
//  two restoring dividers, then a read-modify-write per cell.
//  Read transaction: waits while the output register is full.
//  Ignored transaction: the unit stays idle.
//  After reset the store is swept to 1.0 cell by cell, in_stall_o high.
//  Input stalls while one transaction is in progress; output register holds
//  a result while the input side keeps accepting.
// ----------------------------------------------------------------------------
module face_gradient_limiter_unit #(
  parameter int unsigned CELL_COUNT = fgl_pkg::DefCellCount,
  parameter int unsigned VALUE_BITS = fgl_pkg::DefValueBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  fgl_pkg::cfg_index_t          cfg_index_i,
  input  fgl_pkg::factor_t             cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  fgl_pkg::action_t             action_i,
  input  fgl_pkg::cell_t               owner_cell_i,
  input  fgl_pkg::cell_t               neighbour_cell_i,
  input  logic signed [VALUE_BITS-1:0] owner_value_i,
  input  logic signed [VALUE_BITS-1:0] neighbour_value_i,
  input  logic signed [VALUE_BITS-1:0] owner_extrapolation_i,
  input  logic signed [VALUE_BITS-1:0] neighbour_extrapolation_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output fgl_pkg::limit_t              limiter_value_o
);

  import fgl_pkg::*;

  localparam int unsigned VB       = VALUE_BITS;
  localparam int unsigned AddrW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int unsigned ProdW    = VB + FactorW;
  localparam int unsigned WideW    = ProdW - FracW;
  localparam int unsigned DeltaW   = WideW + 1;
  localparam int unsigned MulSteps = FactorW / MulChunk;
  localparam int unsigned MulCntW  = (MulSteps > 1) ? $clog2(MulSteps) : 1;
  localparam int unsigned DivCntW  = $clog2(FracW);

  typedef enum logic [2:0] {
    StClear, StIdle, StRdDone, StMul, StDelta, StDiv, StUpdRd, StUpdWr
  } state_e;

  state_e             state_q;
  logic [AddrW-1:0]   clr_cnt_q;
  logic               enable_q;
  factor_t            factor_q;
  logic               out_valid_q;
  limit_t             out_q;
  action_t            action_q;
  cell_t              cell_q [2];
  logic [VB-1:0]      ex_q [2];
  logic [VB-1:0]      ko_q, kn_q, kmax_q, kmin_q, span_q;
  logic [ProdW-1:0]   acc_q;
  logic [MulCntW-1:0] mul_cnt_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               over_q [2];
  logic [VB-1:0]      rem_q [2];
  logic [VB-1:0]      den_q [2];
  logic [FracW-1:0]   quo_q [2];
  logic               lane_q;

  logic               accept, out_free;
  logic [VB-1:0]      ko_in, kn_in, kmax_in, kmin_in;
  logic [31:0]        in_own_ext;
  logic [AddrW-1:0]   in_own_addr;
  logic               cell_ok [2];
  logic [31:0]        cell_ext [2];
  logic [AddrW-1:0]   cell_addr [2];
  logic [MulChunk-1:0]    chunk;
  logic [VB+MulChunk-1:0] prod;
  logic [WideW-1:0]   widen;
  logic [VB-1:0]      key_c [2];
  logic [DeltaW-1:0]  up_c [2];
  logic [DeltaW-1:0]  dn_c [2];
  logic [VB-1:0]      mag_c [2];
  logic [DeltaW-1:0]  num_c [2];
  logic               over_c [2];
  logic [VB:0]        sh_c [2];
  logic               ge_c [2];
  logic [VB-1:0]      rem_c [2];

  logic               mem_we, mem_re;
  logic [AddrW-1:0]   mem_waddr, mem_raddr;
  limit_t             mem_wdata, mem_rdata;

  assign cfg_ready_o     = 1'b1;
  assign in_stall_o      = (state_q != StIdle);
  assign out_valid_o     = out_valid_q;
  assign limiter_value_o = out_q;
  assign accept          = in_valid_i && (state_q == StIdle);
  assign out_free        = !out_valid_q || !out_stall_i;

  assign ko_in   = {~owner_value_i[VB-1], owner_value_i[VB-2:0]};
  assign kn_in   = {~neighbour_value_i[VB-1], neighbour_value_i[VB-2:0]};
  assign kmax_in = (ko_in > kn_in) ? ko_in : kn_in;
  assign kmin_in = (ko_in > kn_in) ? kn_in : ko_in;

  assign in_own_ext  = 32'(owner_cell_i);
  assign in_own_addr = in_own_ext[AddrW-1:0];

  assign chunk = factor_q[MulChunk*mul_cnt_q +: MulChunk];
  assign prod  = {{MulChunk{1'b0}}, span_q} * {{VB{1'b0}}, chunk};
  assign widen = acc_q[ProdW-1:FracW];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      cell_ext[i]  = 32'(cell_q[i]);
      cell_ok[i]   = cell_ext[i] < CELL_COUNT;
      cell_addr[i] = cell_ext[i][AddrW-1:0];
      key_c[i]     = (i == 0) ? ko_q : kn_q;
      up_c[i]      = DeltaW'(kmax_q - key_c[i]) + DeltaW'(widen);
      dn_c[i]      = DeltaW'(key_c[i] - kmin_q) + DeltaW'(widen);
      mag_c[i]     = ex_q[i][VB-1] ? (~ex_q[i] + VB'(1)) : ex_q[i];
      num_c[i]     = ex_q[i][VB-1] ? dn_c[i] : up_c[i];
      over_c[i]    = DeltaW'(mag_c[i]) > num_c[i];
      sh_c[i]      = {rem_q[i], 1'b0};
      ge_c[i]      = sh_c[i] >= {1'b0, den_q[i]};
      rem_c[i]     = ge_c[i] ? VB'(sh_c[i] - {1'b0, den_q[i]}) : sh_c[i][VB-1:0];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = LimitOne;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
      end
      StIdle: begin
        mem_re    = accept && (action_i == ActRead);
        mem_raddr = in_own_addr;
      end
      StRdDone: begin
        mem_we    = out_free && cell_ok[0];
        mem_waddr = cell_addr[0];
      end
      StUpdRd: begin
        mem_re    = 1'b1;
        mem_raddr = cell_addr[lane_q];
      end
      StUpdWr: begin
        mem_wdata = limit_t'(quo_q[lane_q]);
        mem_we    = over_q[lane_q] && (limit_t'(quo_q[lane_q]) < mem_rdata);
        mem_waddr = cell_addr[lane_q];
      end
      default: begin
      end
    endcase
  end

  fgl_ram #(
    .Width (LimitW),
    .Depth (CELL_COUNT),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      enable_q    <= 1'b1;
      factor_q    <= '0;
      out_valid_q <= 1'b0;
      mul_cnt_q   <= '0;
      div_cnt_q   <= '0;
      lane_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgEnable: enable_q <= cfg_data_i[0];
          CfgFactor: factor_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          clr_cnt_q <= clr_cnt_q + AddrW'(1);
          if (clr_cnt_q == AddrW'(CELL_COUNT - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (accept) begin
            action_q  <= action_i;
            cell_q[0] <= owner_cell_i;
            cell_q[1] <= neighbour_cell_i;
            ex_q[0]   <= owner_extrapolation_i;
            ex_q[1]   <= neighbour_extrapolation_i;
            ko_q      <= ko_in;
            kn_q      <= kn_in;
            kmax_q    <= kmax_in;
            kmin_q    <= kmin_in;
            span_q    <= kmax_in - kmin_in;
            acc_q     <= '0;
            mul_cnt_q <= '0;
            if (action_i == ActRead) begin
              state_q <= StRdDone;
            end else if ((action_i == ActInterior || action_i == ActBoundary) && enable_q) begin
              state_q <= StMul;
            end
          end
        end
        StRdDone: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= cell_ok[0] ? mem_rdata : LimitOne;
            state_q     <= StIdle;
          end
        end
        StMul: begin
          acc_q     <= acc_q + (ProdW'(prod) << (MulChunk * mul_cnt_q));
          mul_cnt_q <= mul_cnt_q + MulCntW'(1);
          if (mul_cnt_q == MulCntW'(MulSteps - 1)) begin
            state_q <= StDelta;
          end
        end
        StDelta: begin
          for (int i = 0; i < 2; i++) begin
            over_q[i] <= over_c[i] && cell_ok[i] && (i == 0 || action_q == ActInterior);
            rem_q[i]  <= num_c[i][VB-1:0];
            den_q[i]  <= mag_c[i];
            quo_q[i]  <= '0;
          end
          div_cnt_q <= '0;
          state_q   <= StDiv;
        end
        StDiv: begin
          for (int i = 0; i < 2; i++) begin
            rem_q[i] <= rem_c[i];
            quo_q[i] <= {quo_q[i][FracW-2:0], ge_c[i]};
          end
          div_cnt_q <= div_cnt_q + DivCntW'(1);
          if (div_cnt_q == DivCntW'(FracW - 1)) begin
            lane_q  <= 1'b0;
            state_q <= StUpdRd;
          end
        end
        StUpdRd: begin
          state_q <= StUpdWr;
        end
        StUpdWr: begin
          if (!lane_q && action_q == ActInterior) begin
            lane_q  <= 1'b1;
            state_q <= StUpdRd;
          end else begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StRdDone)
    else $error("result appeared without a read transaction");

  a_store_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> mem_wdata <= LimitOne)
    else $error("limiter written above 1.0");

  a_update_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StUpdWr && mem_we) |-> mem_wdata < LimitOne)
    else $error("face update did not lower limiter below 1.0");

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> (in_stall_o && mem_we))
    else $error("store sweep not stalling input or not writing");

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the face gradient limiter against a bit-exact limiter store model:
// directed extremes, then random face/read sequences with random gaps/stalls.
// ----------------------------------------------------------------------------
module testbench;
  import fgl_pkg::*;

  typedef struct {
    action_t act;
    cell_t own;
    cell_t nei;
    logic [31:0] ov;
    logic [31:0] nv;
    logic [31:0] oe;
    logic [31:0] ne;
  } face_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  cfg_index_t cfg_index_i = CfgEnable;
  factor_t cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  action_t action_i = ActInterior;
  cell_t owner_cell_i = '0;
  cell_t neighbour_cell_i = '0;
  logic signed [31:0] owner_value_i = '0;
  logic signed [31:0] neighbour_value_i = '0;
  logic signed [31:0] owner_extrapolation_i = '0;
  logic signed [31:0] neighbour_extrapolation_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  limit_t limiter_value_o;

  face_gradient_limiter_unit dut (.*);

  always #10 clk_i = ~clk_i;

  limit_t limiter_shadow [4096];
  logic enable_shadow;
  factor_t factor_shadow;
  limit_t expected_limits [$];
  face_t pending_faces [$];
  int errors = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit feeding = 1'b0;
  bit in_acc = 1'b0;

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [15:0] ratio16(logic [63:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [15:0] q;
    rem = num;
    q = '0;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  task automatic lower_limit(cell_t c, logic [63:0] up, logic [63:0] dn, logic [31:0] ex);
    logic [63:0] mag;
    logic [15:0] r;
    mag = ex[31] ? 64'(-ex) & 64'hFFFF_FFFF : 64'(ex);
    if (!ex[31] && mag > up) r = ratio16(up, mag);
    else if (ex[31] && mag > dn) r = ratio16(dn, mag);
    else return;
    if (limit_t'(r) < limiter_shadow[c]) limiter_shadow[c] = limit_t'(r);
  endtask

  task automatic predict_limits(face_t f);
    logic [63:0] ko, kn, kmax, kmin, w;
    if (f.act == ActRead) begin
      expected_limits.push_back(limiter_shadow[f.own]);
      limiter_shadow[f.own] = LimitOne;
      return;
    end
    if (f.act == ActUnused || !enable_shadow) return;
    ko = 64'(f.ov ^ 32'h8000_0000);
    kn = 64'(f.nv ^ 32'h8000_0000);
    kmax = ko > kn ? ko : kn;
    kmin = ko > kn ? kn : ko;
    w = ((kmax - kmin) * 64'(factor_shadow)) >> 16;
    lower_limit(f.own, kmax - ko + w, ko - kmin + w, f.oe);
    if (f.act == ActInterior) lower_limit(f.nei, kmax - kn + w, kn - kmin + w, f.ne);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_acc) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (feeding && pending_faces.size() > 0) begin
          face_t f;
          f = pending_faces.pop_front();
          in_valid_i <= 1'b1;
          action_i <= f.act;
          owner_cell_i <= f.own;
          neighbour_cell_i <= f.nei;
          owner_value_i <= f.ov;
          neighbour_value_i <= f.nv;
          owner_extrapolation_i <= f.oe;
          neighbour_extrapolation_i <= f.ne;
          in_gap <= gap_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 2) == 0) out_gap <= gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    in_acc <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      face_t f;
      f = '{action_i, owner_cell_i, neighbour_cell_i, owner_value_i,
            neighbour_value_i, owner_extrapolation_i, neighbour_extrapolation_i};
      predict_limits(f);
    end
    if (out_valid_o && !out_stall_i) begin
      if (expected_limits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: limiter %0d", limiter_value_o);
      end else begin
        limit_t e;
        e = expected_limits.pop_front();
        if (e !== limiter_value_o) begin
          errors++;
          if (errors <= 10)
            $display("limiter mismatch: expected %0d actual %0d", e, limiter_value_o);
        end
      end
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(0, 600000)) - 300000);
      default: return $urandom();
    endcase
  endfunction

  function automatic face_t rand_face(int cells);
    face_t f;
    int k;
    k = $urandom_range(0, 19);
    f.act = k < 9 ? ActInterior : k < 14 ? ActBoundary : k < 19 ? ActRead : ActUnused;
    f.own = $urandom_range(0, 15) == 0 ? cell_t'($urandom()) : cell_t'($urandom_range(0, cells));
    f.nei = $urandom_range(0, 15) == 0 ? cell_t'($urandom()) : cell_t'($urandom_range(0, cells));
    f.ov = rand_value();
    f.nv = rand_value();
    f.oe = rand_value();
    f.ne = rand_value();
    return f;
  endfunction

  task automatic write_reg(cfg_index_t idx, factor_t val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgEnable) enable_shadow = val[0];
    else factor_shadow = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase();
    feeding = 1'b1;
    wait (pending_faces.size() == 0);
    while (in_valid_i || expected_limits.size() != 0) @(posedge clk_i);
    feeding = 1'b0;
    repeat (40) @(posedge clk_i);
  endtask

  task automatic add_face(action_t a, cell_t o, cell_t n, logic [31:0] ov, logic [31:0] nv,
                          logic [31:0] oe, logic [31:0] ne);
    pending_faces.push_back('{a, o, n, ov, nv, oe, ne});
  endtask

  initial begin
    enable_shadow = 1'b1;
    factor_shadow = '0;
    foreach (limiter_shadow[i]) limiter_shadow[i] = LimitOne;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    add_face(ActRead, 12'd0, 12'd0, 0, 0, 0, 0);
    add_face(ActInterior, 12'd1, 12'd2, 32'h10000, 32'h20000, 32'h30000, 32'hFFFE0000);
    add_face(ActInterior, 12'd3, 12'd3, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    add_face(ActInterior, 12'd4, 12'd5, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h1);
    add_face(ActBoundary, 12'd6, 12'd7, 32'h0, 32'h8000, 32'h7FFFFFFF, 32'h80000000);
    add_face(ActBoundary, 12'hFFF, 12'd7, 32'h5, 32'h5, 32'h80000000, 32'h1);
    add_face(ActUnused, 12'd1, 12'd2, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF);
    for (int c = 0; c < 8; c++) add_face(ActRead, cell_t'(c), 12'hFFF, 0, 0, 0, 0);
    add_face(ActRead, 12'hFFF, 12'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    run_phase();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_reg(CfgFactor, 24'hFFFFFF);
        1: write_reg(CfgEnable, 24'd0);
        2: begin write_reg(CfgEnable, 24'd1); write_reg(CfgFactor, 24'h8000); end
        3: write_reg(CfgFactor, factor_t'($urandom()));
        4: write_reg(CfgFactor, 24'd0);
        default: write_reg(CfgFactor, 24'h4000);
      endcase
      for (int i = 0; i < 215; i++) pending_faces.push_back(rand_face(p == 3 ? 4095 : 15));
      run_phase();
    end
    if (errors == 0) $display("** face_gradient_limiter_unit: PASSED **");
    else $display("** face_gradient_limiter_unit: FAILED **");
    $finish;
  end

  initial begin
    #20000000;
    $display("** face_gradient_limiter_unit: FAILED **");
    $finish;
  end

endmodule
